@@ design/windowed_latency_percentile_monitor_macros.svh @@
// Assertion helpers for the checker of this block.
`ifndef WINDOWED_LATENCY_PERCENTILE_MONITOR_MACROS_SVH
`define WINDOWED_LATENCY_PERCENTILE_MONITOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WLPM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("port check failed");

// Consequent must hold in the cycle after the antecedent.
`define WLPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ design/wlpm_pkg.sv @@
package wlpm_pkg;

    localparam int DEPTH = 1024;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SUM_W = CW + 1;
    localparam int PW = AW + 7;

    // floor(x / 100) as (x * RECIP) >> RECIP_SH, exact for x below 2^23
    localparam int RECIP_W = 24;
    localparam int RECIP_SH = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;

    // floor(x / 25) as (x * RECIP25) >> Q25_SH, exact for x below 2^14
    localparam int Q25_SH = 19;
    localparam logic [14:0] RECIP25 = 15'd20972;

    localparam int DIV_NW = 66;
    localparam int DIV_DW = 40;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int ADDR_W = 3;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic [31:0] WINDOW_RESET = 32'd1000;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_MESSAGE = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [55:0] MASK56 = {56{1'b1}};

    typedef struct packed {
        logic [1:0]  func;
        logic [39:0] now_ms;
        logic [31:0] lat_ns;
    } in_item_t;

    typedef struct packed {
        logic [39:0] p50_q8;
        logic [39:0] p90_q8;
        logic [39:0] p99_q8;
        logic [55:0] rate_q8;
        logic        rate_updated;
        logic [47:0] processed_count;
        logic [10:0] window_samples;
        logic        samples_dropped;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    function automatic logic [6:0] pct_val(input logic [1:0] idx);
        logic [6:0] v;
        case (idx)
            2'd0:    v = 7'd50;
            2'd1:    v = 7'd90;
            default: v = 7'd99;
        endcase
        return v;
    endfunction

endpackage

@@ design/wlpm_div.sv @@
module wlpm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  wlpm_pkg::div_req_t  req,
    output wlpm_pkg::div_rsp_t  rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [wlpm_pkg::DIV_CW-1:0] cnt_reg;
    logic [wlpm_pkg::DIV_DW-1:0] rem_reg;
    logic [wlpm_pkg::DIV_DW-1:0] dvs_reg;
    logic [wlpm_pkg::DIV_NW-1:0] quo_reg;

    logic [wlpm_pkg::DIV_DW:0]   shifted;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[wlpm_pkg::DIV_NW-1]};
    assign fits = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= wlpm_pkg::DIV_CW'(wlpm_pkg::DIV_NW);
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
            quo_reg  <= req.dividend;
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring
            rem_reg <= fits ? wlpm_pkg::DIV_DW'(shifted - {1'b0, dvs_reg})
                            : shifted[wlpm_pkg::DIV_DW-1:0];
            quo_reg <= {quo_reg[wlpm_pkg::DIV_NW-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == wlpm_pkg::DIV_CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ design/windowed_latency_percentile_monitor.sv @@
// Channel  | Direction | Handshake          | Beat
// s_       | in        | s_valid / s_ready  | wlpm_pkg::in_item_t
// m_       | out       | m_valid / m_ready  | wlpm_pkg::out_item_t
// cfg      | in        | APB, pready high   | window_ms at address 0
//
// Message beat: handled in the idle state. Record beat: stores the sample, then prunes
// expired samples. Query beat: the rate divider, the prune of expired samples, the
// bitwise rank select over the sample RAM, and each of the three percentile
// interpolations in turn.
// Reset is synchronous, active low; the sample RAM needs no clearing pass.
// A result held on m_ stalls only the next query; other beats go on.
module windowed_latency_percentile_monitor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wlpm_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wlpm_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wlpm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PRUNE_RD  = 4'd1;
    localparam logic [3:0] S_PRUNE_CHK = 4'd2;
    localparam logic [3:0] S_RATE      = 4'd3;
    localparam logic [3:0] S_RATE_WAIT = 4'd4;
    localparam logic [3:0] S_POS       = 4'd5;
    localparam logic [3:0] S_LOFR      = 4'd6;
    localparam logic [3:0] S_SEL       = 4'd7;
    localparam logic [3:0] S_PMUL      = 4'd8;
    localparam logic [3:0] S_PADD      = 4'd9;
    localparam logic [3:0] S_PDIV      = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;

    localparam int AW = wlpm_pkg::AW;
    localparam int CW = wlpm_pkg::CW;
    localparam int PW = wlpm_pkg::PW;
    localparam int MW = PW + wlpm_pkg::RECIP_W;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [wlpm_pkg::SUM_W-1:0] s;
        s = wlpm_pkg::SUM_W'(a) + wlpm_pkg::SUM_W'(b);
        if (s >= wlpm_pkg::SUM_W'(wlpm_pkg::DEPTH)) begin
            s = s - wlpm_pkg::SUM_W'(wlpm_pkg::DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]          state_reg;
    wlpm_pkg::in_item_t  item_reg;
    logic [31:0]         window_reg;
    logic [AW-1:0]       oldest_reg;
    logic [CW-1:0]       count_reg;
    logic [47:0]         msg_reg;
    logic [47:0]         cnt_last_reg;
    logic [39:0]         time_last_reg;
    logic                ovf_reg;
    logic [55:0]         rate_reg;
    logic                rate_upd_reg;

    logic [PW-1:0]       pos_reg [3];
    logic [6:0]          frac_reg [3];
    logic [AW-1:0]       k_reg [6];
    logic [CW-1:0]       hit_reg [6];
    logic [31:0]         pref_reg [6];
    logic [31:0]         hmask_reg;
    logic [4:0]          bit_reg;
    logic [CW-1:0]       idx_reg;
    logic                rdv_reg;
    logic [1:0]          pi_reg;
    logic [38:0]         pa_reg;
    logic [38:0]         pb_reg;
    logic [39:0]         pct_reg [3];
    logic [44:0]         dq_reg;
    logic [4:0]          drem_reg;
    logic [2:0]          dcnt_reg;

    logic                m_valid_reg;
    wlpm_pkg::out_item_t m_data_reg;

    logic [71:0]         mem [wlpm_pkg::DEPTH];
    logic [71:0]         rd_data_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    wlpm_pkg::div_req_t  div_req;
    wlpm_pkg::div_rsp_t  div_rsp;

    logic                accept;
    logic                full;
    logic                rate_due;
    logic [47:0]         delta;
    logic [54:0]         delta_x125;
    logic [38:0]         acc;
    logic [31:0]         lat;
    logic [40:0]         expiry;
    logic                sel_issue;
    logic                sel_end;
    logic [MW-1:0]       lo_prod [3];
    logic [13:0]         dchunk;
    logic [28:0]         dprod;
    logic [8:0]          dq9;
    logic [4:0]          drem;

    assign s_ready = (state_reg == S_IDLE);
    assign accept = s_valid && s_ready;
    assign full = (count_reg == CW'(wlpm_pkg::DEPTH));

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wlpm_pkg::REG_WINDOW) ? window_reg : 32'd0;

    assign wr_en = accept && (s_data.func == wlpm_pkg::FUNC_RECORD);
    assign wr_addr = full ? oldest_reg : ring_add(oldest_reg, count_reg);

    assign sel_issue = (state_reg == S_SEL) && (idx_reg < count_reg);
    assign sel_end = (state_reg == S_SEL) && (idx_reg == count_reg) && !rdv_reg;

    always_comb begin
        rd_en = 1'b0;
        rd_addr = oldest_reg;
        if ((state_reg == S_PRUNE_RD) && (count_reg != '0)) begin
            rd_en = 1'b1;
        end else if (sel_issue) begin
            rd_en = 1'b1;
            rd_addr = ring_add(oldest_reg, idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {s_data.now_ms, s_data.lat_ns};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign lat = rd_data_reg[31:0];
    assign expiry = {1'b0, rd_data_reg[71:32]} + {9'd0, window_reg};

    assign rate_due = item_reg.now_ms > time_last_reg;
    assign delta = msg_reg - cnt_last_reg;
    // 125 * delta; the remaining factor of 2^11 is a shift
    assign delta_x125 = {delta, 7'd0} - {5'd0, delta, 2'd0} + {7'd0, delta};
    assign acc = pa_reg + pb_reg;

    // divide by 25 nine quotient bits per cycle, top chunk first
    assign dchunk = {drem_reg, dq_reg[44:36]};
    assign dprod = 29'(dchunk) * 29'(wlpm_pkg::RECIP25);
    assign dq9 = dprod[wlpm_pkg::Q25_SH +: 9];
    assign drem = 5'(dchunk - 14'(dq9) * 14'd25);

    always_comb begin
        div_req.start = (state_reg == S_RATE) && rate_due;
        div_req.dividend = {delta_x125, 11'd0};
        div_req.divisor = item_reg.now_ms - time_last_reg;
    end

    wlpm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            lo_prod[p] = MW'(pos_reg[p]) * MW'(wlpm_pkg::RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            window_reg    <= wlpm_pkg::WINDOW_RESET;
            oldest_reg    <= '0;
            count_reg     <= '0;
            msg_reg       <= '0;
            cnt_last_reg  <= '0;
            time_last_reg <= '0;
            ovf_reg       <= 1'b0;
            rdv_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == wlpm_pkg::REG_WINDOW)) begin
                window_reg <= pwdata;
            end
            if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rdv_reg <= sel_issue;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        item_reg <= s_data;
                        case (s_data.func)
                            wlpm_pkg::FUNC_RECORD: begin
                                if (full) begin
                                    oldest_reg <= ring_add(oldest_reg, CW'(1));
                                    ovf_reg <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                state_reg <= S_PRUNE_RD;
                            end
                            wlpm_pkg::FUNC_MESSAGE: begin
                                msg_reg <= msg_reg + 1'b1;
                            end
                            wlpm_pkg::FUNC_QUERY: begin
                                state_reg <= S_RATE;
                            end
                            default: begin
                                oldest_reg    <= '0;
                                count_reg     <= '0;
                                msg_reg       <= '0;
                                cnt_last_reg  <= '0;
                                time_last_reg <= s_data.now_ms;
                                ovf_reg       <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RATE: begin
                    rate_upd_reg <= rate_due;
                    rate_reg <= '0;
                    if (rate_due) begin
                        cnt_last_reg  <= msg_reg;
                        time_last_reg <= item_reg.now_ms;
                        state_reg <= S_RATE_WAIT;
                    end else begin
                        state_reg <= S_PRUNE_RD;
                    end
                end
                S_RATE_WAIT: begin
                    if (div_rsp.done) begin
                        rate_reg <= (div_rsp.quotient[65:56] != '0) ? wlpm_pkg::MASK56
                                                                   : div_rsp.quotient[55:0];
                        state_reg <= S_PRUNE_RD;
                    end
                end
                S_PRUNE_RD: begin
                    if (count_reg != '0) begin
                        state_reg <= S_PRUNE_CHK;
                    end else if (item_reg.func == wlpm_pkg::FUNC_QUERY) begin
                        for (int p = 0; p < 3; p++) begin
                            pct_reg[p] <= '0;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PRUNE_CHK: begin
                    if (expiry < {1'b0, item_reg.now_ms}) begin
                        // drop the oldest and look at the next one
                        oldest_reg <= ring_add(oldest_reg, CW'(1));
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_PRUNE_RD;
                    end else if (item_reg.func == wlpm_pkg::FUNC_QUERY) begin
                        state_reg <= S_POS;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_POS: begin
                    for (int p = 0; p < 3; p++) begin
                        pos_reg[p] <= PW'(wlpm_pkg::pct_val(2'(p)))
                                      * PW'(count_reg - 1'b1);
                    end
                    state_reg <= S_LOFR;
                end
                S_LOFR: begin
                    for (int p = 0; p < 3; p++) begin
                        frac_reg[p] <= 7'(pos_reg[p] - PW'(lo_prod[p][wlpm_pkg::RECIP_SH +: AW])
                                          * PW'(100));
                        k_reg[2*p] <= lo_prod[p][wlpm_pkg::RECIP_SH +: AW];
                        k_reg[2*p+1] <= lo_prod[p][wlpm_pkg::RECIP_SH +: AW]
                            + AW'(pos_reg[p] != PW'(lo_prod[p][wlpm_pkg::RECIP_SH +: AW])
                                               * PW'(100));
                    end
                    for (int r = 0; r < 6; r++) begin
                        pref_reg[r] <= '0;
                        hit_reg[r] <= '0;
                    end
                    hmask_reg <= '0;
                    bit_reg <= 5'd31;
                    idx_reg <= '0;
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    if (sel_issue) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rdv_reg) begin
                        for (int r = 0; r < 6; r++) begin
                            if ((((lat ^ pref_reg[r]) & hmask_reg) == '0) && !lat[bit_reg]) begin
                                hit_reg[r] <= hit_reg[r] + 1'b1;
                            end
                        end
                    end
                    if (sel_end) begin
                        // settle one bit of every rank
                        for (int r = 0; r < 6; r++) begin
                            if (CW'(k_reg[r]) >= hit_reg[r]) begin
                                pref_reg[r][bit_reg] <= 1'b1;
                                k_reg[r] <= AW'(CW'(k_reg[r]) - hit_reg[r]);
                            end
                            hit_reg[r] <= '0;
                        end
                        hmask_reg[bit_reg] <= 1'b1;
                        idx_reg <= '0;
                        if (bit_reg == '0) begin
                            pi_reg <= '0;
                            state_reg <= S_PMUL;
                        end else begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end
                S_PMUL: begin
                    pa_reg <= 39'(pref_reg[{pi_reg, 1'b0}]) * 39'(7'd100 - frac_reg[pi_reg]);
                    pb_reg <= 39'(pref_reg[{pi_reg, 1'b1}]) * 39'(frac_reg[pi_reg]);
                    state_reg <= S_PADD;
                end
                S_PADD: begin
                    // acc * 256 / 100 is acc * 64 / 25
                    dq_reg <= {acc, 6'd0};
                    drem_reg <= '0;
                    dcnt_reg <= 3'd5;
                    state_reg <= S_PDIV;
                end
                S_PDIV: begin
                    dq_reg <= {dq_reg[35:0], dq9};
                    drem_reg <= drem;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == 3'd1) begin
                        pct_reg[pi_reg] <= 40'({dq_reg[35:0], dq9});
                        if (pi_reg == 2'd2) begin
                            state_reg <= S_OUT;
                        end else begin
                            pi_reg <= pi_reg + 1'b1;
                            state_reg <= S_PMUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.p50_q8          <= pct_reg[0];
                        m_data_reg.p90_q8          <= pct_reg[1];
                        m_data_reg.p99_q8          <= pct_reg[2];
                        m_data_reg.rate_q8         <= rate_reg;
                        m_data_reg.rate_updated    <= rate_upd_reg;
                        m_data_reg.processed_count <= msg_reg;
                        m_data_reg.window_samples  <= 11'(count_reg);
                        m_data_reg.samples_dropped <= ovf_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

@@ design/wlpm_checker.sv @@
`include "windowed_latency_percentile_monitor_macros.svh"

module wlpm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input wlpm_pkg::in_item_t          s_data,
    input logic                        m_valid,
    input logic                        m_ready,
    input wlpm_pkg::out_item_t         m_data
);

    logic long_beat;

    assign long_beat = s_valid && s_ready && (s_data.func == wlpm_pkg::FUNC_QUERY
                                              || s_data.func == wlpm_pkg::FUNC_RECORD);

    // a stalled result beat holds
    `WLPM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // records and queries close the input in the cycle after they are taken
    `WLPM_ASSERT_NEXT(a_busy_after, aclk, aresetn, long_beat, !s_ready)

    `WLPM_ASSERT_SAME(a_count_bound, aclk, aresetn, m_valid, m_data.window_samples <= 11'(wlpm_pkg::DEPTH))

    `WLPM_ASSERT_SAME(a_rate_zero, aclk, aresetn, m_valid && !m_data.rate_updated, m_data.rate_q8 == '0)

endmodule

bind windowed_latency_percentile_monitor wlpm_checker u_wlpm_checker (.*);

@@ tb/sv/windowed_latency_percentile_monitor_tb.sv @@
module windowed_latency_percentile_monitor_tb;
    import wlpm_pkg::*;

    localparam int RING = 1024;
    localparam logic [47:0] CNT_MASK = {48{1'b1}};

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    windowed_latency_percentile_monitor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow state of the monitor
    logic [39:0] ring_time [RING];
    logic [31:0] ring_lat [RING];
    int unsigned head_idx;
    int unsigned live_cnt;
    logic [47:0] msg_total;
    logic [47:0] msg_at_rate;
    logic [39:0] ms_at_rate;
    logic overflow_flag;
    logic [31:0] window_len;

    out_item_t stats_q[$];
    int errors;
    int checked;
    logic [39:0] clock_ms;

    // receiver controls
    bit hold_off;
    bit calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void drop_stale(logic [39:0] now);
        while (live_cnt > 0 && ({8'd0, ring_time[head_idx]} + window_len) < {8'd0, now}) begin
            head_idx = (head_idx + 1) % RING;
            live_cnt--;
        end
    endfunction

    function automatic logic [39:0] pct_of(ref logic [31:0] srt[$], input int p);
        int unsigned n;
        logic [63:0] pos, lo, fr, hi, acc;
        n = srt.size();
        if (n == 0) return 40'd0;
        pos = p * (n - 1);
        lo = pos / 100;
        fr = pos % 100;
        hi = (fr != 0) ? lo + 1 : lo;
        acc = 64'(srt[lo]) * (100 - fr) + 64'(srt[hi]) * fr;
        return 40'((acc * 256) / 100);
    endfunction

    task automatic apply_item(input in_item_t it);
        out_item_t r;
        logic [31:0] srt[$];
        logic [47:0] delta;
        logic [63:0] el, q, rem, rate;
        int unsigned w;
        case (it.func)
            FUNC_RECORD: begin
                if (live_cnt >= RING) begin
                    ring_time[head_idx] = it.now_ms;
                    ring_lat[head_idx] = it.lat_ns;
                    head_idx = (head_idx + 1) % RING;
                    overflow_flag = 1'b1;
                end else begin
                    w = (head_idx + live_cnt) % RING;
                    ring_time[w] = it.now_ms;
                    ring_lat[w] = it.lat_ns;
                    live_cnt++;
                end
                drop_stale(it.now_ms);
            end
            FUNC_MESSAGE: msg_total = msg_total + 48'd1;
            FUNC_CLEAR: begin
                head_idx = 0;
                live_cnt = 0;
                msg_total = '0;
                msg_at_rate = '0;
                ms_at_rate = it.now_ms;
                overflow_flag = 1'b0;
            end
            default: begin
                r = '0;
                if (it.now_ms > ms_at_rate) begin
                    el = it.now_ms - ms_at_rate;
                    delta = (msg_total - msg_at_rate) & CNT_MASK;
                    q = delta / el;
                    rem = delta % el;
                    if (q > 64'(MASK56) / 256000) rate = 64'(MASK56);
                    else begin
                        rate = q * 256000 + (rem * 256000) / el;
                        if (rate > 64'(MASK56)) rate = 64'(MASK56);
                    end
                    r.rate_q8 = rate[55:0];
                    r.rate_updated = 1'b1;
                    msg_at_rate = msg_total;
                    ms_at_rate = it.now_ms;
                end
                drop_stale(it.now_ms);
                for (int i = 0; i < live_cnt; i++)
                    srt.insert(srt.size(), ring_lat[(head_idx + i) % RING]);
                srt.sort();
                r.p50_q8 = pct_of(srt, 50);
                r.p90_q8 = pct_of(srt, 90);
                r.p99_q8 = pct_of(srt, 99);
                r.processed_count = msg_total;
                r.window_samples = 11'(live_cnt);
                r.samples_dropped = overflow_flag;
                stats_q.insert(stats_q.size(), r);
            end
        endcase
    endtask

    task automatic send_item(input in_item_t it, input bit no_gap);
        if (!no_gap) begin
            while ($urandom_range(99) < 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(it);
    endtask

    task automatic idle_in();
        s_valid <= 1'b0;
    endtask

    task automatic write_window(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        window_len = v;
    endtask

    task automatic drain_and_settle();
        int guard;
        guard = 0;
        idle_in();
        while (stats_q.size() != 0 && guard < 2000000) begin
            @(posedge aclk);
            guard++;
        end
        if (guard >= 2000000) begin
            $display("TEST FAILED");
            $finish;
        end
        repeat (3000) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (stats_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                exp_r = stats_q[0];
                stats_q.delete(0);
                checked++;
                if (m_data !== exp_r) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, m_data);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 10);
    end

    function automatic in_item_t mk(logic [1:0] f, logic [39:0] t, logic [31:0] l);
        in_item_t it;
        it.func = f;
        it.now_ms = t;
        it.lat_ns = l;
        return it;
    endfunction

    typedef struct {
        in_item_t it;
        bit known;
        out_item_t res;
    } dir_row_t;

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        out_item_t z;
        in_item_t it;
        int n_items;
        int k;
        int burst;
        logic [31:0] wins[5];

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        calm = 1'b0;
        errors = 0;
        checked = 0;
        head_idx = 0;
        live_cnt = 0;
        msg_total = '0;
        msg_at_rate = '0;
        ms_at_rate = '0;
        overflow_flag = 1'b0;
        window_len = WINDOW_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: rows with a typed result are checked literally too
        z = '0;
        row.known = 1'b1; row.res = z; row.it = mk(FUNC_QUERY, 40'd0, 32'd0);
        rows.insert(rows.size(), row);
        row.known = 1'b0;
        row.it = mk(FUNC_RECORD, 40'd5, 32'hFFFF_FFFF); rows.insert(rows.size(), row);
        row.it = mk(FUNC_RECORD, 40'd6, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_MESSAGE, 40'd7, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_MESSAGE, 40'd7, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_QUERY, 40'd10, 32'd0); rows.insert(rows.size(), row);
        // same time again: rate not updated
        row.it = mk(FUNC_QUERY, 40'd10, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_RECORD, 40'd2000, 32'd1234); rows.insert(rows.size(), row);
        row.it = mk(FUNC_QUERY, 40'd2000, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_RECORD, 40'd1500, 32'd77); rows.insert(rows.size(), row);
        row.it = mk(FUNC_QUERY, 40'd1500, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_CLEAR, 40'hFF_FFFF_FF00, 32'd0); rows.insert(rows.size(), row);
        row.known = 1'b1; row.res = z;
        row.it = mk(FUNC_QUERY, 40'hFF_FFFF_FF00, 32'd0); rows.insert(rows.size(), row);
        row.known = 1'b0;
        row.it = mk(FUNC_RECORD, 40'hFF_FFFF_FFFF, 32'h8000_0001);
        rows.insert(rows.size(), row);
        row.it = mk(FUNC_MESSAGE, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
        rows.insert(rows.size(), row);
        row.it = mk(FUNC_QUERY, 40'hFF_FFFF_FFFF, 32'd0); rows.insert(rows.size(), row);
        row.it = mk(FUNC_CLEAR, 40'd0, 32'd0); rows.insert(rows.size(), row);
        foreach (rows[i]) begin
            if (rows[i].known) begin
                apply_item(rows[i].it);
                if (stats_q[$] !== rows[i].res) begin
                    errors++;
                    if (errors <= 10) $display("table row %0d predictor disagrees", i);
                end
                // undo the shadow step; send_item replays it
                void'(stats_q.pop_back());
            end
            send_item(rows[i].it, 1'b0);
        end
        drain_and_settle();

        // ring overflow: fill beyond depth under a wide window
        write_window(32'hFFFF_FFFF);
        for (k = 0; k < RING + 20; k++) send_item(mk(FUNC_RECORD, 40'd0, $urandom), 1'b1);
        send_item(mk(FUNC_QUERY, 40'd1, 32'd0), 1'b0);

        // back-pressure: receiver holds off while queries keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (150000) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (k = 0; k < 4; k++) send_item(mk(FUNC_QUERY, 40'd2 + k, 32'd0), 1'b1);
                idle_in();
            end
        join
        send_item(mk(FUNC_CLEAR, 40'd10, 32'd0), 1'b0);
        drain_and_settle();

        wins[0] = 32'd1;
        wins[1] = 32'd20;
        wins[2] = WINDOW_RESET;
        wins[3] = 32'd300;
        wins[4] = 32'hFFFF_FFFF;
        clock_ms = 40'd10;
        n_items = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_window(wins[ph]);
            calm = (ph == 2);
            while (n_items < 175 * (ph + 1)) begin
                k = $urandom_range(99);
                if ($urandom_range(99) < 3) clock_ms = clock_ms + 40'($urandom_range(3000));
                else if ($urandom_range(99) < 40) clock_ms = clock_ms + 40'($urandom_range(4));
                if (k < 55) begin
                    // short burst of records
                    burst = $urandom_range(8, 1);
                    for (int b = 0; b < burst; b++) begin
                        it = mk(FUNC_RECORD, clock_ms,
                                ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5000)));
                        send_item(it, 1'b0);
                        n_items++;
                    end
                end else if (k < 80) begin
                    send_item(mk(FUNC_MESSAGE, clock_ms, $urandom), 1'b0);
                    n_items++;
                end else if (k < 97) begin
                    send_item(mk(FUNC_QUERY, clock_ms, $urandom), 1'b0);
                    n_items++;
                end else begin
                    send_item(mk(FUNC_CLEAR, clock_ms, $urandom), 1'b0);
                    n_items++;
                end
            end
            send_item(mk(FUNC_QUERY, clock_ms, 32'd0), 1'b0);
            drain_and_settle();
        end

        if (errors == 0 && stats_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
